/* src/iebm_pkg.sv */
// ----------------------------------------------------------------------------
// iebm_pkg
// Shared types and constants for the I2C EEPROM byte master.
// ----------------------------------------------------------------------------
package iebm_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_DEV_ADDR   = 2'd0;
  localparam logic [1:0] CFG_PHASE_TCKS = 2'd1;
  localparam logic [1:0] CFG_WAIT_TCKS  = 2'd2;

  // raw request codes on the input
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  localparam logic [6:0]  DEV_ADDR_RST   = 7'h50;
  localparam logic [15:0] PHASE_TCKS_RST = 16'd100;
  localparam logic [23:0] WAIT_TCKS_RST  = 24'd500000;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_READ  = 2'd2
  } req_t;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_START1 = 4'd1,
    PH_DEV_W  = 4'd2,
    PH_ACK1   = 4'd3,
    PH_MEM    = 4'd4,
    PH_ACK2   = 4'd5,
    PH_DATA   = 4'd6,
    PH_ACK3   = 4'd7,
    PH_START2 = 4'd8,
    PH_DEV_R  = 4'd9,
    PH_ACK4   = 4'd10,
    PH_RECV   = 4'd11,
    PH_NACK   = 4'd12,
    PH_STOP   = 4'd13,
    PH_WAIT   = 4'd14,
    PH_DONE   = 4'd15
  } phase_t;

  typedef struct packed {
    logic [6:0]  device_address;
    logic [15:0] phase_ticks;
    logic [23:0] write_wait_ticks;
  } cfg_t;

  typedef struct packed {
    req_t       kind;
    logic [7:0] mem_addr;
    logic [7:0] write_data;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic       ack_error;
    logic [7:0] read_data;
  } res_t;

endpackage

/* src/iebm_front.sv */
// ----------------------------------------------------------------------------
// iebm_front
// Input side: decodes the request code and queues items for the engine.
// ----------------------------------------------------------------------------
module iebm_front
  import iebm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_mode,
  input  logic [7:0] in_mem_addr,
  input  logic [7:0] in_write_data,
  input  logic       in_sda_in,
  output logic       q_valid,
  output item_t      q_item,
  input  logic       q_ready
);

  item_t      mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push, pop;
  item_t      item_in;

  always_comb begin
    case (in_mode)
      MODE_WRITE: item_in.kind = REQ_WRITE;
      MODE_READ:  item_in.kind = REQ_READ;
      MODE_TICK:  item_in.kind = REQ_TICK;
      default:    item_in.kind = REQ_TICK;   // unused code: plain tick
    endcase
    item_in.mem_addr   = in_mem_addr;
    item_in.write_data = in_write_data;
    item_in.sda_in     = in_sda_in;
  end

  assign in_ready = (count_r != 2'd2);
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = mem_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

/* src/iebm_engine.sv */
// ----------------------------------------------------------------------------
// iebm_engine
// Bus sequencer: advances the I2C transfer by one tick per queued item.
// ----------------------------------------------------------------------------
module iebm_engine
  import iebm_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  logic  item_valid,
  input  item_t item,
  output logic  item_ready,
  output logic  res_valid,
  output res_t  res,
  input  logic  res_ready
);

  phase_t      phase_r, phase_nxt;
  logic [1:0]  step_r, step_nxt;
  logic [2:0]  bit_cnt_r, bit_cnt_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [23:0] tick_r, tick_nxt;
  logic        is_read_r, is_read_nxt;
  logic [7:0]  held_addr_r, held_addr_nxt;
  logic [7:0]  held_data_r, held_data_nxt;
  logic        scl_r, scl_nxt;
  logic        sda_r, sda_nxt;
  logic        err_r, err_nxt;
  logic [7:0]  last_rd_r, last_rd_nxt;
  logic        done_nxt;
  logic        step_en;
  logic [15:0] pt_m1;
  logic [7:0]  dev_w;

  assign step_en    = item_valid && res_ready;
  assign item_ready = res_ready;
  assign res_valid  = step_en;

  // zero phase ticks behaves as one
  assign pt_m1 = (cfg.phase_ticks == 16'd0) ? 16'd0 : cfg.phase_ticks - 16'd1;
  assign dev_w = {cfg.device_address, 1'b0};

  always_comb begin
    logic fin;
    fin           = 1'b0;
    phase_nxt     = phase_r;
    step_nxt      = step_r;
    bit_cnt_nxt   = bit_cnt_r;
    shift_nxt     = shift_r;
    tick_nxt      = tick_r;
    is_read_nxt   = is_read_r;
    held_addr_nxt = held_addr_r;
    held_data_nxt = held_data_r;
    scl_nxt       = scl_r;
    sda_nxt       = sda_r;
    err_nxt       = err_r;
    last_rd_nxt   = last_rd_r;
    done_nxt      = 1'b0;

    if (step_en) begin
      if (phase_r == PH_IDLE && (item.kind == REQ_WRITE || item.kind == REQ_READ)) begin
        held_addr_nxt = item.mem_addr;
        held_data_nxt = item.write_data;
        is_read_nxt   = (item.kind == REQ_READ);
        err_nxt       = 1'b0;
        phase_nxt     = PH_START1;
        step_nxt      = 2'd0;
        bit_cnt_nxt   = 3'd0;
        tick_nxt      = 24'd0;
      end

      if (phase_nxt != PH_IDLE) begin
        if (tick_nxt != 24'd0) begin
          tick_nxt = tick_nxt - 24'd1;
        end else begin
          tick_nxt = {8'd0, pt_m1};
          case (phase_nxt)
            PH_START1, PH_START2: begin
              if (step_nxt == 2'd0) begin
                sda_nxt  = 1'b1;
                scl_nxt  = 1'b1;
                step_nxt = 2'd1;
              end else if (step_nxt == 2'd1) begin
                sda_nxt  = 1'b0;
                step_nxt = 2'd2;
              end else begin
                scl_nxt     = 1'b0;
                step_nxt    = 2'd0;
                bit_cnt_nxt = 3'd0;
                if (phase_nxt == PH_START1) begin
                  phase_nxt = PH_DEV_W;
                  shift_nxt = dev_w;
                end else begin
                  phase_nxt = PH_DEV_R;
                  shift_nxt = dev_w | 8'h01;
                end
              end
            end
            PH_DEV_W, PH_MEM, PH_DATA, PH_DEV_R: begin
              if (step_nxt == 2'd0) begin
                scl_nxt  = 1'b0;
                sda_nxt  = shift_nxt[7];
                step_nxt = 2'd1;
              end else begin
                scl_nxt   = 1'b1;
                shift_nxt = {shift_nxt[6:0], 1'b0};
                step_nxt  = 2'd0;
                if (bit_cnt_nxt == 3'd7) begin
                  bit_cnt_nxt = 3'd0;
                  case (phase_nxt)
                    PH_DEV_W: phase_nxt = PH_ACK1;
                    PH_MEM:   phase_nxt = PH_ACK2;
                    PH_DATA:  phase_nxt = PH_ACK3;
                    default:  phase_nxt = PH_ACK4;
                  endcase
                end else begin
                  bit_cnt_nxt = bit_cnt_nxt + 3'd1;
                end
              end
            end
            PH_ACK1, PH_ACK2, PH_ACK3, PH_ACK4: begin
              if (step_nxt == 2'd0) begin
                scl_nxt  = 1'b0;
                sda_nxt  = 1'b1;
                step_nxt = 2'd1;
              end else if (step_nxt == 2'd1) begin
                scl_nxt  = 1'b1;
                step_nxt = 2'd2;
              end else if (item.sda_in) begin
                // no acknowledge: abort, first stop edge on this tick
                err_nxt   = 1'b1;
                sda_nxt   = 1'b0;
                scl_nxt   = 1'b1;
                phase_nxt = PH_STOP;
                step_nxt  = 2'd1;
              end else begin
                scl_nxt  = 1'b0;
                step_nxt = 2'd0;
                case (phase_nxt)
                  PH_ACK1: begin
                    phase_nxt   = PH_MEM;
                    bit_cnt_nxt = 3'd0;
                    shift_nxt   = held_addr_nxt;
                  end
                  PH_ACK2: begin
                    if (is_read_nxt) begin
                      phase_nxt = PH_START2;
                    end else begin
                      phase_nxt   = PH_DATA;
                      bit_cnt_nxt = 3'd0;
                      shift_nxt   = held_data_nxt;
                    end
                  end
                  PH_ACK3: phase_nxt = PH_STOP;
                  default: begin
                    phase_nxt   = PH_RECV;
                    bit_cnt_nxt = 3'd0;
                    shift_nxt   = 8'd0;
                  end
                endcase
              end
            end
            PH_RECV: begin
              if (step_nxt == 2'd0) begin
                scl_nxt  = 1'b1;
                step_nxt = 2'd1;
              end else begin
                shift_nxt = {shift_nxt[6:0], item.sda_in};
                scl_nxt   = 1'b0;
                step_nxt  = 2'd0;
                if (bit_cnt_nxt == 3'd7) begin
                  bit_cnt_nxt = 3'd0;
                  phase_nxt   = PH_NACK;
                end else begin
                  bit_cnt_nxt = bit_cnt_nxt + 3'd1;
                end
              end
            end
            PH_NACK: begin
              if (step_nxt == 2'd0) begin
                scl_nxt  = 1'b0;
                step_nxt = 2'd1;
              end else if (step_nxt == 2'd1) begin
                sda_nxt  = 1'b1;
                step_nxt = 2'd2;
              end else begin
                scl_nxt   = 1'b1;
                phase_nxt = PH_STOP;
                step_nxt  = 2'd0;
              end
            end
            PH_STOP: begin
              if (step_nxt == 2'd0) begin
                sda_nxt  = 1'b0;
                scl_nxt  = 1'b1;
                step_nxt = 2'd1;
              end else begin
                sda_nxt   = 1'b1;
                step_nxt  = 2'd0;
                phase_nxt = (is_read_nxt || err_nxt) ? PH_DONE : PH_WAIT;
              end
            end
            PH_WAIT: begin
              if (cfg.write_wait_ticks == 24'd0) begin
                fin = 1'b1;
              end else begin
                tick_nxt  = cfg.write_wait_ticks - 24'd1;
                phase_nxt = PH_DONE;
                step_nxt  = 2'd0;
              end
            end
            default: fin = 1'b1;
          endcase

          if (fin) begin
            if (is_read_nxt && !err_nxt) begin
              last_rd_nxt = shift_nxt;
            end
            phase_nxt = PH_IDLE;
            step_nxt  = 2'd0;
            tick_nxt  = 24'd0;
            done_nxt  = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    res.scl_out   = scl_nxt;
    res.sda_out   = sda_nxt;
    res.busy_res  = (phase_nxt != PH_IDLE);
    res.done_res  = done_nxt;
    res.ack_error = err_nxt;
    res.read_data = last_rd_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      step_r      <= 2'd0;
      bit_cnt_r   <= 3'd0;
      shift_r     <= 8'd0;
      tick_r      <= 24'd0;
      is_read_r   <= 1'b0;
      held_addr_r <= 8'd0;
      held_data_r <= 8'd0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      err_r       <= 1'b0;
      last_rd_r   <= 8'd0;
    end else begin
      phase_r     <= phase_nxt;
      step_r      <= step_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      shift_r     <= shift_nxt;
      tick_r      <= tick_nxt;
      is_read_r   <= is_read_nxt;
      held_addr_r <= held_addr_nxt;
      held_data_r <= held_data_nxt;
      scl_r       <= scl_nxt;
      sda_r       <= sda_nxt;
      err_r       <= err_nxt;
      last_rd_r   <= last_rd_nxt;
    end
  end

endmodule

/* src/iebm_outq.sv */
// ----------------------------------------------------------------------------
// iebm_outq
// Result buffer: two-entry queue between the engine and the output channel.
// ----------------------------------------------------------------------------
module iebm_outq
  import iebm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       res_valid,
  input  res_t       res,
  output logic       res_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_scl_out,
  output logic       out_sda_out,
  output logic       out_busy_res,
  output logic       out_done_res,
  output logic       out_ack_error,
  output logic [7:0] out_read_data
);

  res_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push, pop;
  res_t       head;

  assign res_ready = (count_r != 2'd2);
  assign out_valid = (count_r != 2'd0);
  assign push      = res_valid && res_ready;
  assign pop       = out_valid && out_ready;
  assign head      = mem_r[rd_ptr_r];

  assign out_scl_out   = head.scl_out;
  assign out_sda_out   = head.sda_out;
  assign out_busy_res  = head.busy_res;
  assign out_done_res  = head.done_res;
  assign out_ack_error = head.ack_error;
  assign out_read_data = head.read_data;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= res;
    end
  end

endmodule

/* src/i2c_eeprom_byte_master.sv */
// ----------------------------------------------------------------------------
// i2c_eeprom_byte_master
// I2C master for single-byte EEPROM writes and reads, one tick per item.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in       input      in_valid/in_ready    mode, mem_addr, write_data, sda_in
//  out      output     out_valid/out_ready  scl, sda, busy, done, ack_error, read_data
//  cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  One item accepted and one result produced per cycle when neither side stalls.
//  An accepted item is registered in the input queue, then in the result queue, before its result is valid.
//  The sequencer steps only when the result queue has room; both queues are two deep.
//  Synchronous active-low reset; config writes are always accepted.
// ----------------------------------------------------------------------------
module i2c_eeprom_byte_master
  import iebm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_mem_addr,
  input  logic [7:0]  in_write_data,
  input  logic        in_sda_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_scl_out,
  output logic        out_sda_out,
  output logic        out_busy_res,
  output logic        out_done_res,
  output logic        out_ack_error,
  output logic [7:0]  out_read_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  cfg_t  cfg_r, cfg_nxt;
  logic  q_valid, q_ready;
  item_t q_item;
  logic  res_valid, res_ready;
  res_t  res;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_DEV_ADDR:   cfg_nxt.device_address   = cfg_data[6:0];
        CFG_PHASE_TCKS: cfg_nxt.phase_ticks      = cfg_data[15:0];
        CFG_WAIT_TCKS:  cfg_nxt.write_wait_ticks = cfg_data;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.device_address   <= DEV_ADDR_RST;
      cfg_r.phase_ticks      <= PHASE_TCKS_RST;
      cfg_r.write_wait_ticks <= WAIT_TCKS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  iebm_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_mem_addr   (in_mem_addr),
    .in_write_data (in_write_data),
    .in_sda_in     (in_sda_in),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_ready       (q_ready)
  );

  iebm_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item_valid (q_valid),
    .item       (q_item),
    .item_ready (q_ready),
    .res_valid  (res_valid),
    .res        (res),
    .res_ready  (res_ready)
  );

  iebm_outq u_outq (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (res_valid),
    .res           (res),
    .res_ready     (res_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_scl_out   (out_scl_out),
    .out_sda_out   (out_sda_out),
    .out_busy_res  (out_busy_res),
    .out_done_res  (out_done_res),
    .out_ack_error (out_ack_error),
    .out_read_data (out_read_data)
  );

endmodule
